// ===== src/fskm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fskm_pkg;

    // sine table geometry
    localparam int TABLE_ADDR_BITS = 10;
    localparam int QUARTER_BITS    = TABLE_ADDR_BITS - 2;
    localparam int QUARTER_LEN     = 1 << QUARTER_BITS;

    // phase accumulator and symbol length
    localparam int PHASE_W                = 32;
    localparam int MAX_SAMPLES_PER_SYMBOL = 64;
    localparam int IDX_W                  = $clog2(MAX_SAMPLES_PER_SYMBOL);
    localparam int SPS_W                  = 7;
    localparam int SAMPLE_W               = 8;
    localparam int MAG_W                  = 7;

    // configuration register reset values
    localparam logic [PHASE_W-1:0] TONE_STEP_ZERO_RST = 32'd536870912;
    localparam logic [PHASE_W-1:0] TONE_STEP_ONE_RST  = 32'd805306368;
    localparam logic [SPS_W-1:0]   SAMPLES_PER_SYM_RST = 7'd16;

    // queue depths
    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int OUT_DEPTH = 2;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

    // fixed point constants for the table build
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
    localparam longint      ONE_Q30    = 64'sd1073741824;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_TONE_STEP_ZERO = 2'd0,
        CFG_TONE_STEP_ONE  = 2'd1,
        CFG_SAMPLES_PER_SYM = 2'd2
    } cfg_index_t;

    // back end sequencer states
    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

    // classified symbol handed from front to back
    typedef struct packed {
        logic               tone_on;
        logic [PHASE_W-1:0] step;
        logic [IDX_W-1:0]   last_idx;
    } cmd_t;

    // one output word
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] i_sample;
        logic signed [SAMPLE_W-1:0] q_sample;
        logic                       last_sample;
    } out_word_t;

    typedef logic [MAG_W-1:0] quarter_tab_t [QUARTER_LEN+1];

    // one Taylor step: t * x^2 in Q30
    function automatic logic [63:0] taylor_mul(logic [63:0] t, logic [63:0] x);
        logic [63:0] p;
        p = (t * x) >> 30;
        p = (p * x) >> 30;
        return p;
    endfunction

    // quarter wave magnitude at table index k, evaluated at elaboration
    function automatic logic [MAG_W-1:0] sine_mag(int k);
        logic [63:0] x;
        logic [63:0] t;
        longint      s;
        logic [63:0] m;
        x = (64'(k) * TWO_PI_Q30) >> TABLE_ADDR_BITS;
        s = longint'(x);
        t = x;
        t = taylor_mul(t, x) / 64'd6;
        s = s - longint'(t);
        t = taylor_mul(t, x) / 64'd20;
        s = s + longint'(t);
        t = taylor_mul(t, x) / 64'd42;
        s = s - longint'(t);
        t = taylor_mul(t, x) / 64'd72;
        s = s + longint'(t);
        t = taylor_mul(t, x) / 64'd110;
        s = s - longint'(t);
        t = taylor_mul(t, x) / 64'd156;
        s = s + longint'(t);
        t = taylor_mul(t, x) / 64'd210;
        s = s - longint'(t);
        if (s < 0)
        begin
            s = 0;
        end
        if (s > ONE_Q30)
        begin
            s = ONE_Q30;
        end
        m = (64'(s) * 64'd127 + 64'd4096) >> 30;
        if (m > 64'd127)
        begin
            m = 64'd127;
        end
        return m[MAG_W-1:0];
    endfunction

    function automatic quarter_tab_t build_quarter();
        quarter_tab_t tab;
        for (int k = 0; k <= QUARTER_LEN; k++)
        begin
            tab[k] = sine_mag(k);
        end
        return tab;
    endfunction

    localparam quarter_tab_t QUARTER_TAB = build_quarter();

    // signed sine of a full wave index, -127..127
    function automatic logic signed [SAMPLE_W-1:0] wave(logic [TABLE_ADDR_BITS-1:0] idx);
        logic [1:0]              quad;
        logic [QUARTER_BITS:0]   addr;
        logic [MAG_W-1:0]        mag;
        logic [SAMPLE_W-1:0]     val;
        quad = idx[TABLE_ADDR_BITS-1 -: 2];
        if (quad[0])
        begin
            addr = (QUARTER_BITS+1)'(QUARTER_LEN) - {1'b0, idx[QUARTER_BITS-1:0]};
        end
        else
        begin
            addr = {1'b0, idx[QUARTER_BITS-1:0]};
        end
        mag = QUARTER_TAB[addr];
        val = {1'b0, mag};
        if (quad[1])
        begin
            val = -val;
        end
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== src/fsk_symbol_modulator_top.sv =====
// Binary FSK modulator, one symbol word in, a burst of I/Q sample words out.
// Input side is a queue: drive tone_on and bit_value with push while full is
// low. Output side is a queue too: while empty is low, i_sample, q_sample and
// last_sample show the oldest sample word, and pop takes it.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index selects
// tone_step_zero (0), tone_step_one (1) or samples_per_symbol (2), other
// indexes are ignored. cfg_ready is always high. Write only while idle.
// Path: a pushed symbol passes through the symbol queue, the sequencer's
// command register and the output queue before its first sample shows.
// Throughput: the back end NCO sequencer emits one sample word per clock while
// the output queue has room; a symbol is samples_per_symbol words (1..64, 16
// after reset), and bursts of consecutive symbols run back to back with no gap.
// Reset: step and length registers return to their defaults, phase clears to
// zero and both queues empty.
// Stall: when pop stays low the two word output queue fills and the sequencer
// holds its phase; the two entry symbol queue then fills and full rises.
`timescale 1ns / 1ps
`default_nettype none

module fsk_symbol_modulator_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          tone_on,
    input  wire logic                          bit_value,
    output logic                               empty,
    input  wire logic                          pop,
    output logic signed [fskm_pkg::SAMPLE_W-1:0] i_sample,
    output logic signed [fskm_pkg::SAMPLE_W-1:0] q_sample,
    output logic                               last_sample,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [fskm_pkg::PHASE_W-1:0]  cfg_data
);

    logic           cmd_wr;
    fskm_pkg::cmd_t cmd_wr_data;
    logic           cmd_rd;
    logic           cmd_valid;
    fskm_pkg::cmd_t cmd_rd_data;

    // front end: config and symbol classification
    fskm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .tone_on   (tone_on),
        .bit_value (bit_value),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_wr    (cmd_wr),
        .cmd_out   (cmd_wr_data)
    );

    // symbol queue between front and back
    fskm_cmd_queue u_cmd_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (cmd_wr),
        .wr_data  (cmd_wr_data),
        .full     (full),
        .rd       (cmd_rd),
        .rd_valid (cmd_valid),
        .rd_data  (cmd_rd_data)
    );

    // back end: NCO sequencer and output queue
    fskm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_in      (cmd_rd_data),
        .cmd_rd      (cmd_rd),
        .pop         (pop),
        .empty       (empty),
        .i_sample    (i_sample),
        .q_sample    (q_sample),
        .last_sample (last_sample)
    );

endmodule

`default_nettype wire

// ===== src/fskm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fskm_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire logic                       full,
    input  wire logic                       tone_on,
    input  wire logic                       bit_value,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [1:0]                 cfg_index,
    input  wire logic [fskm_pkg::PHASE_W-1:0] cfg_data,
    output logic                            cmd_wr,
    output fskm_pkg::cmd_t                  cmd_out
);

    logic [fskm_pkg::PHASE_W-1:0] step_zero_reg;
    logic [fskm_pkg::PHASE_W-1:0] step_one_reg;
    logic [fskm_pkg::SPS_W-1:0]   sps_reg;
    logic [fskm_pkg::SPS_W-1:0]   count;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_zero_reg <= fskm_pkg::TONE_STEP_ZERO_RST;
            step_one_reg  <= fskm_pkg::TONE_STEP_ONE_RST;
            sps_reg       <= fskm_pkg::SAMPLES_PER_SYM_RST;
        end
        else if (cfg_valid)
        begin
            unique case (fskm_pkg::cfg_index_t'(cfg_index))
                fskm_pkg::CFG_TONE_STEP_ZERO:  step_zero_reg <= cfg_data;
                fskm_pkg::CFG_TONE_STEP_ONE:   step_one_reg  <= cfg_data;
                fskm_pkg::CFG_SAMPLES_PER_SYM: sps_reg <= cfg_data[fskm_pkg::SPS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // clamp samples per symbol into 1..max
    always_comb
    begin
        count = sps_reg;
        if (sps_reg == '0)
        begin
            count = fskm_pkg::SPS_W'(1);
        end
        else if (sps_reg > fskm_pkg::SPS_W'(fskm_pkg::MAX_SAMPLES_PER_SYMBOL))
        begin
            count = fskm_pkg::SPS_W'(fskm_pkg::MAX_SAMPLES_PER_SYMBOL);
        end
    end

    // classify the incoming symbol word
    always_comb
    begin
        cmd_wr           = push && !full;
        cmd_out.tone_on  = tone_on;
        cmd_out.step     = bit_value ? step_one_reg : step_zero_reg;
        cmd_out.last_idx = fskm_pkg::IDX_W'(count - fskm_pkg::SPS_W'(1));
    end

endmodule

`default_nettype wire

// ===== src/fskm_cmd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fskm_cmd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr,
    input  fskm_pkg::cmd_t      wr_data,
    output logic                full,
    input  wire logic           rd,
    output logic                rd_valid,
    output fskm_pkg::cmd_t      rd_data
);

    localparam int CNT_W = $clog2(fskm_pkg::CMD_DEPTH + 1);

    fskm_pkg::cmd_t                  mem_reg [fskm_pkg::CMD_DEPTH];
    logic [fskm_pkg::CMD_PTR_W-1:0]  wr_ptr_reg;
    logic [fskm_pkg::CMD_PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]                cnt_reg;
    logic [CNT_W-1:0]                cnt_next;

    assign full     = (cnt_reg == CNT_W'(fskm_pkg::CMD_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr && !(rd && rd_valid))
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (!wr && rd && rd_valid)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + fskm_pkg::CMD_PTR_W'(1);
            end
            if (rd && rd_valid)
            begin
                rd_ptr_reg <= rd_ptr_reg + fskm_pkg::CMD_PTR_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/fskm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fskm_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    input  fskm_pkg::cmd_t                     cmd_in,
    output logic                               cmd_rd,
    input  wire logic                          pop,
    output logic                               empty,
    output logic signed [fskm_pkg::SAMPLE_W-1:0] i_sample,
    output logic signed [fskm_pkg::SAMPLE_W-1:0] q_sample,
    output logic                               last_sample
);

    localparam int CNT_W = $clog2(fskm_pkg::OUT_DEPTH + 1);

    fskm_pkg::back_state_t          state_reg;
    fskm_pkg::back_state_t          state_next;
    fskm_pkg::cmd_t                 cmd_reg;
    fskm_pkg::cmd_t                 cmd_next;
    logic [fskm_pkg::IDX_W-1:0]     idx_reg;
    logic [fskm_pkg::IDX_W-1:0]     idx_next;
    logic [fskm_pkg::PHASE_W-1:0]   phase_reg;
    logic [fskm_pkg::PHASE_W-1:0]   phase_next;

    fskm_pkg::out_word_t            ofifo_reg [fskm_pkg::OUT_DEPTH];
    logic [fskm_pkg::OUT_PTR_W-1:0] owr_ptr_reg;
    logic [fskm_pkg::OUT_PTR_W-1:0] ord_ptr_reg;
    logic [CNT_W-1:0]               ocnt_reg;
    logic [CNT_W-1:0]               ocnt_next;

    logic                                  out_rd;
    logic                                  out_space;
    logic                                  emit;
    logic                                  is_last;
    logic [fskm_pkg::TABLE_ADDR_BITS-1:0]  sin_idx;
    logic [fskm_pkg::TABLE_ADDR_BITS-1:0]  cos_idx;
    fskm_pkg::out_word_t                   word;

    assign empty  = (ocnt_reg == '0);
    assign out_rd = pop && !empty;
    assign out_space = (ocnt_reg != CNT_W'(fskm_pkg::OUT_DEPTH)) || out_rd;

    // sample generation from the current phase
    always_comb
    begin
        sin_idx = phase_reg[fskm_pkg::PHASE_W-1 -: fskm_pkg::TABLE_ADDR_BITS];
        cos_idx = sin_idx + fskm_pkg::TABLE_ADDR_BITS'(fskm_pkg::QUARTER_LEN);
        is_last = (idx_reg == cmd_reg.last_idx);
        word.last_sample = is_last;
        if (cmd_reg.tone_on)
        begin
            word.i_sample = fskm_pkg::wave(cos_idx);
            word.q_sample = fskm_pkg::wave(sin_idx);
        end
        else
        begin
            word.i_sample = '0;
            word.q_sample = '0;
        end
    end

    // sequencer: next state and outputs
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        emit       = 1'b0;
        cmd_rd     = 1'b0;
        unique case (state_reg)
            fskm_pkg::BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_rd     = 1'b1;
                    cmd_next   = cmd_in;
                    idx_next   = '0;
                    state_next = fskm_pkg::BK_RUN;
                end
            end
            fskm_pkg::BK_RUN:
            begin
                if (out_space)
                begin
                    emit       = 1'b1;
                    phase_next = cmd_reg.tone_on ? phase_reg + cmd_reg.step : '0;
                    idx_next   = idx_reg + fskm_pkg::IDX_W'(1);
                    if (is_last)
                    begin
                        // chain straight into the next symbol when one waits
                        if (cmd_valid)
                        begin
                            cmd_rd   = 1'b1;
                            cmd_next = cmd_in;
                            idx_next = '0;
                        end
                        else
                        begin
                            state_next = fskm_pkg::BK_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = fskm_pkg::BK_IDLE;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fskm_pkg::BK_IDLE;
            idx_reg   <= '0;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    // output queue occupancy
    always_comb
    begin
        ocnt_next = ocnt_reg;
        if (emit && !out_rd)
        begin
            ocnt_next = ocnt_reg + CNT_W'(1);
        end
        else if (!emit && out_rd)
        begin
            ocnt_next = ocnt_reg - CNT_W'(1);
        end
    end

    // output queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_ptr_reg <= '0;
            ord_ptr_reg <= '0;
            ocnt_reg    <= '0;
        end
        else
        begin
            ocnt_reg <= ocnt_next;
            if (emit)
            begin
                owr_ptr_reg <= owr_ptr_reg + fskm_pkg::OUT_PTR_W'(1);
            end
            if (out_rd)
            begin
                ord_ptr_reg <= ord_ptr_reg + fskm_pkg::OUT_PTR_W'(1);
            end
        end
    end

    // output queue storage
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ofifo_reg[owr_ptr_reg] <= word;
        end
    end

    assign i_sample    = ofifo_reg[ord_ptr_reg].i_sample;
    assign q_sample    = ofifo_reg[ord_ptr_reg].q_sample;
    assign last_sample = ofifo_reg[ord_ptr_reg].last_sample;

endmodule

`default_nettype wire

// ===== src/fskm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fskm_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire logic                          full,
    input  wire logic                          empty,
    input  wire logic                          pop,
    input  wire logic signed [fskm_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic signed [fskm_pkg::SAMPLE_W-1:0] q_sample,
    input  wire logic                          last_sample,
    input  wire logic                          cfg_ready
);

    // nothing waits on either side once reset has been seen by a clock edge
    a_reset_clear: assert property (@(posedge clk) !rst_n |=> (empty && !full && cfg_ready))
        else $error("queues not clear during reset");

    // samples never reach the negative full scale code
    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (i_sample != -8'sd128 && q_sample != -8'sd128))
        else $error("sample outside -127..127");

    // a waiting word is not withdrawn
    a_word_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result word withdrawn");

    // a waiting word holds its value
    a_word_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(i_sample) && $stable(q_sample) && $stable(last_sample)))
        else $error("result word changed while stalled");

endmodule

bind fsk_symbol_modulator_top fskm_checker u_checker (.*);

`default_nettype wire

// ===== sim/fsk_symbol_modulator_top_test.sv =====
`timescale 1ns / 1ps

module fsk_symbol_modulator_top_test;
    import fskm_pkg::*;

    // out of range register index, must be ignored by the block
    localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;
    localparam int SYMBOLS_PER_PHASE = 30;
    localparam int RANDOM_PHASES     = 8;
    localparam int MAX_REPORTS       = 40;

    typedef struct {
        logic tone;
        logic bit_sel;
    } symbol_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] i_val;
        logic signed [SAMPLE_W-1:0] q_val;
        logic                       is_last;
    } sample_t;

    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       push        = 1'b0;
    logic                       full;
    logic                       tone_on     = 1'b0;
    logic                       bit_value   = 1'b0;
    logic                       empty;
    logic                       pop         = 1'b0;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic signed [SAMPLE_W-1:0] q_sample;
    logic                       last_sample;
    logic                       cfg_valid   = 1'b0;
    logic                       cfg_ready;
    logic [1:0]                 cfg_index   = 2'd0;
    logic [PHASE_W-1:0]         cfg_data    = '0;

    // symbol words still to be offered, sample words still owed
    symbol_t pending_symbols[$];
    sample_t expected_samples[$];

    // local copy of the modulator state and registers
    logic [MAG_W-1:0]   mag_lut [0:QUARTER_LEN];
    logic [PHASE_W-1:0] nco_phase;
    logic [PHASE_W-1:0] step_bit0;
    logic [PHASE_W-1:0] step_bit1;
    logic [SPS_W-1:0]   burst_len_raw;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count   = 0;

    fsk_symbol_modulator_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .tone_on     (tone_on),
        .bit_value   (bit_value),
        .empty       (empty),
        .pop         (pop),
        .i_sample    (i_sample),
        .q_sample    (q_sample),
        .last_sample (last_sample),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // signed sine at a full wave index from the quarter wave magnitudes
    function automatic logic signed [SAMPLE_W-1:0] signed_sine(logic [TABLE_ADDR_BITS-1:0] idx);
        logic [1:0]              quad;
        logic [QUARTER_BITS-1:0] offs;
        logic [SAMPLE_W-1:0]     v;
        quad = idx[TABLE_ADDR_BITS-1 -: 2];
        offs = idx[QUARTER_BITS-1:0];
        if (quad[0])
        begin
            v = {1'b0, mag_lut[QUARTER_LEN - int'(offs)]};
        end
        else
        begin
            v = {1'b0, mag_lut[offs]};
        end
        if (quad[1])
        begin
            v = -v;
        end
        return v;
    endfunction

    // expand one accepted symbol word into its burst of sample words
    function automatic void expand_symbol(logic tone, logic sel);
        logic [PHASE_W-1:0]         step;
        logic [TABLE_ADDR_BITS-1:0] idx;
        int                         count;
        sample_t                    smp;
        step  = sel ? step_bit1 : step_bit0;
        count = int'(burst_len_raw);
        if (count == 0)
        begin
            count = 1;
        end
        if (count > MAX_SAMPLES_PER_SYMBOL)
        begin
            count = MAX_SAMPLES_PER_SYMBOL;
        end
        for (int n = 0; n < count; n++)
        begin
            if (tone)
            begin
                idx       = nco_phase[PHASE_W-1 -: TABLE_ADDR_BITS];
                smp.i_val = signed_sine(idx + TABLE_ADDR_BITS'(QUARTER_LEN));
                smp.q_val = signed_sine(idx);
                nco_phase = nco_phase + step;
            end
            else
            begin
                smp.i_val = '0;
                smp.q_val = '0;
                nco_phase = '0;
            end
            smp.is_last = (n == count - 1);
            expected_samples.insert(expected_samples.size(), smp);
        end
    endfunction

    // symbol word driver
    always @(posedge clk or negedge rst_n)
    begin : symbol_drive
        symbol_t nxt;
        if (!rst_n)
        begin
            push      <= 1'b0;
            tone_on   <= 1'b0;
            bit_value <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                expand_symbol(tone_on, bit_value);
            end
            if (!push || !full)
            begin
                if (pending_symbols.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_symbols.pop_front();
                    push      <= 1'b1;
                    tone_on   <= nxt.tone;
                    bit_value <= nxt.bit_sel;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // sample word monitor
    always @(posedge clk or negedge rst_n)
    begin : sample_check
        sample_t want;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_samples.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                    begin
                        $display("%0t: unexpected sample word i=%0d q=%0d last=%0b",
                                 $time, i_sample, q_sample, last_sample);
                    end
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (i_sample !== want.i_val || q_sample !== want.q_val
                        || last_sample !== want.is_last)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                        begin
                            $display("%0t: i_sample expected %0d actual %0d", $time,
                                     want.i_val, i_sample);
                            $display("%0t: q_sample expected %0d actual %0d", $time,
                                     want.q_val, q_sample);
                            $display("%0t: last_sample expected %0b actual %0b", $time,
                                     want.is_last, last_sample);
                        end
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic add_symbol(input logic tone, input logic sel);
        symbol_t s;
        s.tone    = tone;
        s.bit_sel = sel;
        pending_symbols.insert(pending_symbols.size(), s);
    endtask

    // block until every symbol word is taken and every sample word has come
    task automatic wait_drained();
        while (push || pending_symbols.size() != 0 || expected_samples.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // one register write on the configuration channel
    task automatic write_reg(input logic [1:0] idx, input logic [PHASE_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TONE_STEP_ZERO:  step_bit0     = val;
            CFG_TONE_STEP_ONE:   step_bit1     = val;
            CFG_SAMPLES_PER_SYM: burst_len_raw = val[SPS_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [PHASE_W-1:0] pick_step();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin : run_test
        logic [63:0]        ang;
        logic [63:0]        term;
        logic [63:0]        prod;
        longint             acc;
        logic [PHASE_W-1:0] len_word;

        // quarter wave magnitudes, fixed point Taylor series of sine
        for (int k = 0; k <= QUARTER_LEN; k++)
        begin
            ang  = (64'(k) * TWO_PI_Q30) >> TABLE_ADDR_BITS;
            term = ang;
            acc  = longint'(ang);
            for (int n = 1; n <= 7; n++)
            begin
                term = (term * ang) >> 30;
                term = (term * ang) >> 30;
                term = term / (64'(2 * n) * 64'(2 * n + 1));
                if (n % 2 == 1)
                begin
                    acc = acc - longint'(term);
                end
                else
                begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0)
            begin
                acc = 0;
            end
            if (acc > ONE_Q30)
            begin
                acc = ONE_Q30;
            end
            prod = acc;
            prod = (prod * 64'd127 + 64'd4096) >> 30;
            if (prod > 64'd127)
            begin
                prod = 64'd127;
            end
            mag_lut[k] = prod[MAG_W-1:0];
        end

        // register defaults after reset
        step_bit0     = TONE_STEP_ZERO_RST;
        step_bit1     = TONE_STEP_ONE_RST;
        burst_len_raw = SAMPLES_PER_SYM_RST;
        nco_phase     = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // default registers: both tones, silence clears the phase
        add_symbol(1'b1, 1'b0);
        add_symbol(1'b1, 1'b0);
        add_symbol(1'b1, 1'b1);
        add_symbol(1'b1, 1'b1);
        add_symbol(1'b0, 1'b0);
        add_symbol(1'b0, 1'b1);
        add_symbol(1'b1, 1'b1);
        add_symbol(1'b1, 1'b0);
        wait_drained();

        // single sample symbols, zero and full scale steps, ignored index
        write_reg(CFG_SAMPLES_PER_SYM, 32'd1);
        write_reg(CFG_TONE_STEP_ZERO, 32'd0);
        write_reg(CFG_TONE_STEP_ONE, 32'hFFFF_FFFF);
        write_reg(CFG_UNUSED_INDEX, 32'hFFFF_FFFF);
        add_symbol(1'b1, 1'b0);
        add_symbol(1'b1, 1'b0);
        add_symbol(1'b1, 1'b1);
        add_symbol(1'b1, 1'b1);
        add_symbol(1'b1, 1'b1);
        add_symbol(1'b0, 1'b1);
        add_symbol(1'b1, 1'b1);
        wait_drained();

        // longest symbols, half and quarter turn steps
        write_reg(CFG_SAMPLES_PER_SYM, 32'd64);
        write_reg(CFG_TONE_STEP_ZERO, 32'h8000_0000);
        write_reg(CFG_TONE_STEP_ONE, 32'h4000_0000);
        add_symbol(1'b1, 1'b1);
        add_symbol(1'b1, 1'b0);
        add_symbol(1'b0, 1'b0);
        wait_drained();

        // zero length, after masking, behaves as one sample
        write_reg(CFG_SAMPLES_PER_SYM, 32'hFFFF_FF80);
        add_symbol(1'b1, 1'b1);
        add_symbol(1'b1, 1'b1);
        wait_drained();
        write_reg(CFG_SAMPLES_PER_SYM, 32'd0);
        add_symbol(1'b1, 1'b0);
        add_symbol(1'b0, 1'b1);
        wait_drained();

        // length above the maximum saturates
        write_reg(CFG_SAMPLES_PER_SYM, 32'd100);
        add_symbol(1'b1, 1'b0);
        wait_drained();

        // random phases over the idling modes
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 45;
                    recv_idle_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 45;
                end
                default:
                begin
                    send_idle_pct = 23;
                    recv_idle_pct = 23;
                end
            endcase
            write_reg(CFG_TONE_STEP_ZERO, pick_step());
            write_reg(CFG_TONE_STEP_ONE, pick_step());
            if (ph == 5)
            begin
                len_word = 32'd64;
            end
            else if ($urandom_range(3) == 0)
            begin
                len_word = $urandom;
            end
            else
            begin
                len_word = $urandom_range(8, 1);
            end
            write_reg(CFG_SAMPLES_PER_SYM, len_word);
            if ($urandom_range(1) == 1)
            begin
                write_reg(CFG_UNUSED_INDEX, $urandom);
            end
            for (int n = 0; n < SYMBOLS_PER_PHASE; n++)
            begin
                add_symbol($urandom_range(99) < 80, $urandom_range(1));
                // sender holds off mid phase until the output side is drained
                if (n == SYMBOLS_PER_PHASE / 2)
                begin
                    wait_drained();
                end
            end
            wait_drained();
        end

        // allow for any stray sample words
        repeat (16) @(posedge clk);
        if (error_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
